// File: src/sliding_window_median_top_macros.svh
// ----------------------------------------------------------------------------
// Sliding window median - assertion macros
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_TOP_MACROS_SVH

// same-cycle implication
`define SWM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swm check failed");

// next-cycle implication
`define SWM_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swm check failed");

`endif

// File: src/swm_pkg.sv
// ----------------------------------------------------------------------------
// Sliding window median - package
// Sizes, item field types and the link between neighboring sort cells.
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 32;

    localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CNT_W = $clog2(WINDOW_MAX + 1);

    typedef logic signed [31:0]          sample_t;
    typedef logic signed [32:0]          median_t;
    typedef logic        [6:0]           wsize_t;
    typedef logic signed [SAMPLE_BITS-1:0] val_t;
    typedef logic        [IDX_W-1:0]     idx_t;
    typedef logic        [CNT_W-1:0]     cnt_t;

    // what a cell shows its neighbors
    typedef struct packed {
        val_t val;
        logic gt;     // entry above the new item (or empty)
        logic eq;     // entry equals the evicted item
        logic below;  // entry sits below the evicted slot
        logic le;     // compacted entry at this slot is <= new item
    } cell_link_t;

    localparam cell_link_t LINK_LO_EDGE = '{val: '0, gt: 1'b0, eq: 1'b0,
                                           below: 1'b1, le: 1'b1};
    localparam cell_link_t LINK_HI_EDGE = '{val: '0, gt: 1'b1, eq: 1'b0,
                                           below: 1'b0, le: 1'b0};

endpackage

// File: src/swm_if.sv
// ----------------------------------------------------------------------------
// Sliding window median - channel interfaces
// Valid/ready channels for samples, medians and the window size register.
// ----------------------------------------------------------------------------
interface swm_in_if;
    logic             valid;
    logic             ready;
    swm_pkg::sample_t sample;
    logic             start_req;

    modport source (output valid, sample, start_req, input ready);
    modport sink   (input valid, sample, start_req, output ready);
endinterface

interface swm_out_if;
    logic             valid;
    logic             ready;
    swm_pkg::median_t median_doubled;

    modport source (output valid, median_doubled, input ready);
    modport sink   (input valid, median_doubled, output ready);
endinterface

interface swm_cfg_if;
    logic            valid;
    logic            ready;
    swm_pkg::wsize_t window_size;

    modport source (output valid, window_size, input ready);
    modport sink   (input valid, window_size, output ready);
endinterface

// File: src/swm_cell.sv
// ----------------------------------------------------------------------------
// Sliding window median - sort cell
// One slot of the sorted window; drops the evicted item and inserts the new
// one using only its own entry and those of its two neighbors.
// ----------------------------------------------------------------------------
module swm_cell (
    input  logic                clk,
    input  logic                load,
    input  logic                full,
    input  logic                valid,
    input  swm_pkg::val_t       din,
    input  swm_pkg::val_t       oldest,
    input  swm_pkg::cell_link_t lo,
    input  swm_pkg::cell_link_t hi,
    output swm_pkg::cell_link_t link
);
    import swm_pkg::*;

    val_t v_reg;
    val_t v_next;
    logic above_old;
    logic evict;

    always_comb
    begin
        link.val  = v_reg;
        link.gt   = !valid || (v_reg > din);
        link.eq   = valid && (v_reg == oldest);
        above_old = !valid || (v_reg > oldest);
        evict     = link.eq && !hi.eq;   // topmost copy of the evicted value
        link.below = full ? (!above_old && !evict) : valid;
        link.le    = link.below ? !link.gt : !hi.gt;
    end

    always_comb
    begin
        priority if (link.le)
        begin
            v_next = link.below ? v_reg : hi.val;
        end
        else if (lo.le)
        begin
            v_next = din;
        end
        else
        begin
            v_next = lo.below ? lo.val : v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            v_reg <= v_next;
        end
    end

endmodule

// File: src/swm_ring.sv
// ----------------------------------------------------------------------------
// Sliding window median - arrival ring
// Samples in arrival order; prefetches the entry that the next item evicts.
// ----------------------------------------------------------------------------
module swm_ring (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  swm_pkg::idx_t wr_addr,
    input  swm_pkg::val_t wr_data,
    input  swm_pkg::idx_t rd_addr,
    output swm_pkg::val_t oldest
);
    import swm_pkg::*;

    val_t mem [WINDOW_MAX];
    val_t rd_q;
    val_t last_reg;
    logic fwd_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
            rd_q         <= mem[rd_addr];
            last_reg     <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg <= 1'b0;
        end
        else if (wr_en)
        begin
            fwd_reg <= (rd_addr == wr_addr);
        end
    end

    assign oldest = fwd_reg ? last_reg : rd_q;

endmodule

// File: src/sliding_window_median_top.sv
// ----------------------------------------------------------------------------
// Sliding window median - top level
// Running median over the last window_size samples, given as twice its value.
// ----------------------------------------------------------------------------
// Takes one sample per clock as long as results are taken; a sample loads the
// sort cells and pend_reg, then its result goes to out_data_reg. The rate is
// set by the row of WINDOW_MAX sort cells, which evict the oldest item and
// insert the new one in the same cycle, with the arrival ring prefetching
// the next evicted item through its registered read port. No result is
// given until the window holds window_size samples. Writing window_size or
// raising start_req empties the window; no clearing pass follows reset.
module sliding_window_median_top (
    input  logic      clk,
    input  logic      rst_n,
    swm_in_if.sink    samples,
    swm_out_if.source medians,
    swm_cfg_if.sink   cfg
);
    import swm_pkg::*;

    wsize_t  window_size_reg;
    idx_t    ring_pos_reg;
    cnt_t    fill_count_reg;
    logic    pend_reg;
    logic    out_valid_reg;
    median_t out_data_reg;

    logic    in_acc;
    logic    cfg_acc;
    logic    move;
    cnt_t    w_eff;
    logic    clear;
    cnt_t    fill_eff;
    idx_t    pos_eff;
    cnt_t    pos_inc;
    idx_t    pos_next;
    logic    full;
    cnt_t    fill_next;
    logic    result;
    val_t    din;
    val_t    oldest;
    idx_t    mid_lo;
    idx_t    mid_hi;
    median_t med;

    val_t       cell_val  [WINDOW_MAX];
    cell_link_t link      [WINDOW_MAX];
    cell_link_t lo_link   [WINDOW_MAX];
    cell_link_t hi_link   [WINDOW_MAX];
    logic       cell_valid[WINDOW_MAX];

    assign cfg.ready     = 1'b1;
    assign cfg_acc       = cfg.valid && cfg.ready;
    assign move          = pend_reg && (!out_valid_reg || medians.ready);
    assign samples.ready = !pend_reg || move;
    assign in_acc        = samples.valid && samples.ready;

    always_comb
    begin
        priority if (window_size_reg == '0)
        begin
            w_eff = CNT_W'(1);
        end
        else if (int'(window_size_reg) > WINDOW_MAX)
        begin
            w_eff = CNT_W'(WINDOW_MAX);
        end
        else
        begin
            w_eff = CNT_W'(window_size_reg);
        end
    end

    always_comb
    begin
        din       = val_t'(samples.sample);
        clear     = samples.start_req || (fill_count_reg > w_eff);
        fill_eff  = clear ? '0 : fill_count_reg;
        pos_eff   = (clear || (CNT_W'(ring_pos_reg) >= w_eff)) ? '0 : ring_pos_reg;
        pos_inc   = CNT_W'(pos_eff) + CNT_W'(1);
        pos_next  = (pos_inc >= w_eff) ? '0 : pos_inc[IDX_W-1:0];
        full      = (fill_eff == w_eff);
        fill_next = full ? w_eff : fill_eff + CNT_W'(1);
        result    = (fill_next == w_eff);
    end

    swm_ring u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (in_acc),
        .wr_addr (pos_eff),
        .wr_data (din),
        .rd_addr (pos_next),
        .oldest  (oldest)
    );

    for (genvar i = 0; i < WINDOW_MAX; i++)
    begin : g_cell
        assign cell_valid[i] = (CNT_W'(i) < fill_eff);
        assign cell_val[i]   = link[i].val;

        if (i == 0)
        begin : g_lo_edge
            assign lo_link[i] = LINK_LO_EDGE;
        end
        else
        begin : g_lo
            assign lo_link[i] = link[i-1];
        end

        if (i == WINDOW_MAX - 1)
        begin : g_hi_edge
            assign hi_link[i] = LINK_HI_EDGE;
        end
        else
        begin : g_hi
            assign hi_link[i] = link[i+1];
        end

        swm_cell u_cell (
            .clk    (clk),
            .load   (in_acc),
            .full   (full),
            .valid  (cell_valid[i]),
            .din    (din),
            .oldest (oldest),
            .lo     (lo_link[i]),
            .hi     (hi_link[i]),
            .link   (link[i])
        );
    end

    // odd window: both picks hit the middle entry
    always_comb
    begin
        mid_lo = IDX_W'((w_eff - CNT_W'(1)) >> 1);
        mid_hi = IDX_W'(w_eff >> 1);
        med    = 33'(cell_val[mid_lo]) + 33'(cell_val[mid_hi]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= wsize_t'(3);
            ring_pos_reg    <= '0;
            fill_count_reg  <= '0;
        end
        else if (cfg_acc)
        begin
            window_size_reg <= cfg.window_size;
            ring_pos_reg    <= '0;
            fill_count_reg  <= '0;
        end
        else if (in_acc)
        begin
            ring_pos_reg   <= pos_next;
            fill_count_reg <= fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                pend_reg <= result;
            end
            else if (move)
            begin
                pend_reg <= 1'b0;
            end

            if (move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (medians.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_data_reg <= med;
        end
    end

    assign medians.valid          = out_valid_reg;
    assign medians.median_doubled = out_data_reg;

endmodule

// File: src/swm_checker.sv
// ----------------------------------------------------------------------------
// Sliding window median - port checker
// Checks on the top level's handshakes, bound to every instance.
// ----------------------------------------------------------------------------
`include "sliding_window_median_top_macros.svh"

module swm_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input swm_pkg::median_t out_data,
    input logic             cfg_valid,
    input logic             cfg_ready
);

    `SWM_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))
    `SWM_ASSERT_IMP(a_rise_after_item, $rose(out_valid), $past(in_valid && in_ready, 2))
    `SWM_ASSERT_IMP(a_stall_only_blocked, !in_ready, out_valid && !out_ready)
    `SWM_ASSERT_IMP(a_cfg_taken, cfg_valid, cfg_ready)

endmodule

bind sliding_window_median_top swm_checker u_swm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (medians.valid),
    .out_ready (medians.ready),
    .out_data  (medians.median_doubled),
    .cfg_valid (cfg.valid),
    .cfg_ready (cfg.ready)
);

// File: tb/sv/tb_sliding_window_median_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window median - testbench
// Streams signed samples through the filter under several window sizes,
// random idling on both channels and one long output stall. A predictor
// keeps its own sorted window and arrival ring and checks every median.
// ----------------------------------------------------------------------------
module tb_sliding_window_median_top;
    import swm_pkg::*;

    localparam int      CYCLE_LIMIT = 200000;
    localparam int      DRAIN_WAIT  = 8;
    localparam int      LONG_HOLD   = 300;
    localparam sample_t S_MIN       = 32'sh8000_0000;
    localparam sample_t S_MAX       = 32'sh7FFF_FFFF;
    localparam int      NUM_PHASES  = 10;

    typedef struct {
        sample_t sample;
        logic    start_req;
    } sample_item_t;

    logic clk;
    logic rst_n;

    swm_in_if  in_if();
    swm_out_if out_if();
    swm_cfg_if cfg_if();

    sliding_window_median_top DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (in_if),
        .medians (out_if),
        .cfg     (cfg_if)
    );

    sample_item_t sample_q[$];
    median_t      median_q[$];
    sample_item_t next_item;
    median_t      want;

    // predictor state
    sample_t win_sorted[WINDOW_MAX];
    sample_t win_ring[WINDOW_MAX];
    int      ring_pos;
    int      fill;
    wsize_t  win_cfg;

    logic in_taken;
    logic cfg_taken;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic hold_armed;
    logic hold_used;
    int   hold_left;
    int   err_count;
    int   cycles;

    wsize_t phase_w[NUM_PHASES] = '{7'd5, 7'd2, 7'd64, 7'd1, 7'd7, 7'd0, 7'd127,
                                    7'd4, 7'd16, 7'd33};
    int     phase_n[NUM_PHASES] = '{60, 80, 130, 60, 70, 40, 100, 80, 60, 60};

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void predict_median(sample_t s, logic start);
        int      w;
        int      i;
        int      j;
        sample_t old;
        median_t m;
        w = (win_cfg == 0) ? 1 : ((win_cfg > WINDOW_MAX) ? WINDOW_MAX : int'(win_cfg));
        if (start || fill > w)
        begin
            ring_pos = 0;
            fill     = 0;
        end
        if (ring_pos >= w)
            ring_pos = 0;
        if (fill == w)
        begin
            old = win_ring[ring_pos];
            i = 0;
            while (i < w && win_sorted[i] != old)
                i++;
            for (; i + 1 < w; i++)
                win_sorted[i] = win_sorted[i + 1];
            j = w - 1;
        end
        else
        begin
            j = fill;
            fill++;
        end
        while (j > 0 && win_sorted[j - 1] > s)
        begin
            win_sorted[j] = win_sorted[j - 1];
            j--;
        end
        win_sorted[j] = s;
        win_ring[ring_pos] = s;
        ring_pos = (ring_pos + 1 >= w) ? 0 : ring_pos + 1;
        if (fill == w)
        begin
            if (w % 2 == 1)
                m = {win_sorted[w / 2], 1'b0};
            else
                m = median_t'(win_sorted[w / 2 - 1]) + median_t'(win_sorted[w / 2]);
            median_q = {median_q, m};
        end
    endfunction

    function automatic sample_t rand_sample();
        sample_t v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6:    v = sample_t'($urandom_range(8)) - 4;
            7:
            begin
                case ($urandom_range(3))
                    0:       v = S_MIN;
                    1:       v = S_MAX;
                    2:       v = '0;
                    default: v = -1;
                endcase
            end
            default:    v = sample_t'($urandom_range(2000)) - 1000;
        endcase
        return v;
    endfunction

    task automatic queue_item(sample_t s, logic st);
        sample_item_t it;
        it.sample    = s;
        it.start_req = st;
        sample_q = {sample_q, it};
    endtask

    task automatic wait_drained();
        while (sample_q.size() != 0 || in_if.valid || median_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_window(wsize_t w);
        wait_drained();
        cfg_if.valid       <= 1'b1;
        cfg_if.window_size <= w;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_if.valid <= 1'b0;
    endtask

    // driver
    always @(negedge clk)
    begin
        if (!rst_n)
            in_if.valid <= 1'b0;
        else if (!in_if.valid || in_taken)
        begin
            if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_item = sample_q.pop_front();
                in_if.valid     <= 1'b1;
                in_if.sample    <= next_item.sample;
                in_if.start_req <= next_item.start_req;
            end
            else
                in_if.valid <= 1'b0;
        end
    end

    // long hold-off counter
    always @(negedge clk)
    begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
        else if (hold_armed && !hold_used)
        begin
            hold_used <= 1'b1;
            hold_left <= LONG_HOLD;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            out_if.ready <= 1'b0;
        else if (hold_left != 0 || (hold_armed && !hold_used))
            out_if.ready <= 1'b0;
        else
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("sliding_window_median_top: mismatch");
            $finish;
        end
        if (!rst_n)
        begin
            in_taken  <= 1'b0;
            cfg_taken <= 1'b0;
        end
        else
        begin
            in_taken  <= in_if.valid && in_if.ready;
            cfg_taken <= cfg_if.valid && cfg_if.ready;
            if (cfg_if.valid && cfg_if.ready)
            begin
                win_cfg  = cfg_if.window_size;
                ring_pos = 0;
                fill     = 0;
            end
            if (in_if.valid && in_if.ready)
                predict_median(in_if.sample, in_if.start_req);
            if (out_if.valid && out_if.ready)
            begin
                if (median_q.size() == 0)
                begin
                    if (err_count < 10)
                        $display("unexpected median: got %0d", out_if.median_doubled);
                    err_count++;
                end
                else
                begin
                    want = median_q.pop_front();
                    if (out_if.median_doubled !== want)
                    begin
                        if (err_count < 10)
                            $display("median_doubled: expected %0d, got %0d",
                                     want, out_if.median_doubled);
                        err_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        in_if.valid        = 1'b0;
        in_if.sample       = '0;
        in_if.start_req    = 1'b0;
        out_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.window_size = '0;
        win_cfg            = 7'd3;
        ring_pos           = 0;
        fill               = 0;
        hold_armed         = 1'b0;
        hold_used          = 1'b0;
        hold_left          = 0;
        err_count          = 0;
        cycles             = 0;
        send_idle_pct      = 32;
        recv_idle_pct      = 46;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset window size, extremes, start mid-stream
        queue_item(S_MIN, 1'b0);
        queue_item(S_MAX, 1'b0);
        queue_item('0, 1'b0);
        queue_item(-1, 1'b0);
        queue_item(S_MAX, 1'b0);
        queue_item(7, 1'b1);
        queue_item(7, 1'b0);
        queue_item(-3, 1'b0);

        // single-sample window, start gives a median at once
        write_window(7'd1);
        queue_item(S_MAX, 1'b0);
        queue_item(S_MIN, 1'b0);
        queue_item(5, 1'b1);

        // even window: sums of extremes
        write_window(7'd2);
        queue_item(S_MAX, 1'b0);
        queue_item(S_MAX, 1'b0);
        queue_item(S_MIN, 1'b0);
        queue_item(S_MIN, 1'b0);
        queue_item(S_MIN, 1'b0);

        // zero acts as one
        write_window(7'd0);
        queue_item(-5, 1'b0);
        queue_item(9, 1'b1);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == 3)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 32;
            end
            else if (p == 7)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_window(phase_w[p]);
            for (int k = 0; k < phase_n[p]; k++)
                queue_item(rand_sample(), ($urandom_range(49) == 0));
            if (p == 1)
                hold_armed = 1'b1;
        end

        wait_drained();
        if (err_count == 0)
            $display("sliding_window_median_top: match");
        else
            $display("sliding_window_median_top: mismatch");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/swm_pkg.sv
src/swm_if.sv
src/swm_cell.sv
src/swm_ring.sv
src/sliding_window_median_top.sv
src/swm_checker.sv
tb/sv/tb_sliding_window_median_top.sv
